// ===== design/pmm_pkg.sv =====
// ----------------------------------------------------------------------------
// pmm_pkg
// Types and constants shared by the masked-match rule table and its checker.
// ----------------------------------------------------------------------------
package pmm_pkg;

  // Fixed field widths of the item interface.
  localparam int MODE_W = 2;
  localparam int SLOT_W = 6;
  localparam int FIELD_W = 64;
  localparam int PRIO_W = 16;

  // Number of slots that the slot field can address.
  localparam int SLOT_SPAN = 2 ** SLOT_W;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MATCH  = 2'd2;

  // Status codes of a result item.
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // One input item.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] lookup_key;
    logic [FIELD_W-1:0] rule_mask;
    logic [PRIO_W-1:0]  rule_priority;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic              status;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [PRIO_W-1:0] hit_priority;
  } out_item_t;

  // Control part of an item as it travels from cell to cell; key and mask
  // travel beside it at the table's key width.
  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] rule_priority;
    logic              status;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [PRIO_W-1:0] hit_priority;
  } pmm_ctl_t;

endpackage

// ===== design/pmm_cell.sv =====
// ----------------------------------------------------------------------------
// pmm_cell
// One rule slot of the table. It holds the rule and one pipeline stage of
// the item chain: each passing item is applied to this slot and handed on.
// ----------------------------------------------------------------------------
module pmm_cell #(
  parameter int INDEX     = 0,
  parameter int KEY_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  pmm_pkg::pmm_ctl_t     prev_ctl,
  input  logic [KEY_WIDTH-1:0]  prev_key,
  input  logic [KEY_WIDTH-1:0]  prev_mask,
  output pmm_pkg::pmm_ctl_t     ctl_r,
  output logic [KEY_WIDTH-1:0]  key_r,
  output logic [KEY_WIDTH-1:0]  mask_r
);

  // Slots past what the slot field can name are never addressed.
  localparam bit IN_RANGE = INDEX < pmm_pkg::SLOT_SPAN;
  localparam logic [pmm_pkg::SLOT_W-1:0] MY_SLOT = pmm_pkg::SLOT_W'(INDEX);

  // Stored rule.
  logic                        rule_valid_r, rule_valid_nxt;
  logic [KEY_WIDTH-1:0]        rule_key_r, rule_key_nxt;
  logic [KEY_WIDTH-1:0]        rule_care_r, rule_care_nxt;
  logic [pmm_pkg::PRIO_W-1:0]  rule_rank_r, rule_rank_nxt;

  pmm_pkg::pmm_ctl_t           ctl_nxt;
  logic                        slot_here;
  logic                        take;
  logic                        key_eq;

  assign slot_here = IN_RANGE && (prev_ctl.slot == MY_SLOT);
  assign take      = advance && prev_ctl.valid;
  assign key_eq    = (prev_key & rule_care_r) == rule_key_r;

  // Apply the passing item to this slot.
  always_comb begin
    ctl_nxt        = prev_ctl;
    rule_valid_nxt = rule_valid_r;
    rule_key_nxt   = rule_key_r;
    rule_care_nxt  = rule_care_r;
    rule_rank_nxt  = rule_rank_r;
    case (prev_ctl.mode)
      pmm_pkg::MODE_INSERT: begin
        if (slot_here) begin
          rule_valid_nxt = 1'b1;
          rule_key_nxt   = prev_key & prev_mask;
          rule_care_nxt  = prev_mask;
          rule_rank_nxt  = prev_ctl.rule_priority;
        end
      end
      pmm_pkg::MODE_REMOVE: begin
        if (slot_here && rule_valid_r) begin
          rule_valid_nxt = 1'b0;
          ctl_nxt.status = pmm_pkg::STATUS_DONE;
        end
      end
      pmm_pkg::MODE_MATCH: begin
        // Slots are visited in rising order, so a strict compare keeps the
        // lowest slot among equal priorities.
        if (rule_valid_r && key_eq &&
            (!prev_ctl.hit || (rule_rank_r > prev_ctl.hit_priority))) begin
          ctl_nxt.hit          = 1'b1;
          ctl_nxt.hit_slot     = MY_SLOT;
          ctl_nxt.hit_priority = rule_rank_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state: rule valid bit and stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_valid_r <= 1'b0;
      ctl_r.valid  <= 1'b0;
    end else if (advance) begin
      ctl_r.valid <= prev_ctl.valid;
      if (take) begin
        rule_valid_r <= rule_valid_nxt;
      end
    end
  end

  // Payload of the stage and of the rule.
  always_ff @(posedge clk) begin
    if (advance) begin
      ctl_r.mode          <= ctl_nxt.mode;
      ctl_r.slot          <= ctl_nxt.slot;
      ctl_r.rule_priority <= ctl_nxt.rule_priority;
      ctl_r.status        <= ctl_nxt.status;
      ctl_r.hit           <= ctl_nxt.hit;
      ctl_r.hit_slot      <= ctl_nxt.hit_slot;
      ctl_r.hit_priority  <= ctl_nxt.hit_priority;
      key_r               <= prev_key;
      mask_r              <= prev_mask;
    end
    if (take) begin
      rule_key_r  <= rule_key_nxt;
      rule_care_r <= rule_care_nxt;
      rule_rank_r <= rule_rank_nxt;
    end
  end

endmodule

// ===== design/priority_masked_match_table.sv =====
// ----------------------------------------------------------------------------
// priority_masked_match_table
// Path: an accepted item passes every cell register, then the output register.
// Throughput: one item per cycle, set by the chain of rule cells, one stage
// per slot; the chain holds only while its last stage waits on a full output.
// Reset clears every rule valid bit and every stage at once; no clearing pass.
// Masked-match rule table: insert, remove and highest-priority match.
// ----------------------------------------------------------------------------
module priority_masked_match_table #(
  parameter int ENTRIES   = 64,
  parameter int KEY_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pmm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pmm_pkg::out_item_t out_data
);

  pmm_pkg::pmm_ctl_t    chain_ctl  [ENTRIES+1];
  logic [KEY_WIDTH-1:0] chain_key  [ENTRIES+1];
  logic [KEY_WIDTH-1:0] chain_mask [ENTRIES+1];

  logic                 advance;
  logic                 out_valid_r, out_valid_nxt;
  pmm_pkg::out_item_t   out_data_r, out_data_nxt;
  pmm_pkg::pmm_ctl_t    tail;

  assign tail = chain_ctl[ENTRIES];

  // The chain moves unless its last item has nowhere to go.
  assign advance  = !(tail.valid && out_valid_r && !out_ready);
  assign in_ready = advance;

  // Entry into the chain; a remove starts out as not found.
  always_comb begin
    chain_ctl[0].valid         = in_valid;
    chain_ctl[0].mode          = in_data.mode;
    chain_ctl[0].slot          = in_data.slot;
    chain_ctl[0].rule_priority = in_data.rule_priority;
    chain_ctl[0].status        = (in_data.mode == pmm_pkg::MODE_REMOVE) ?
                                 pmm_pkg::STATUS_EMPTY : pmm_pkg::STATUS_DONE;
    chain_ctl[0].hit           = 1'b0;
    chain_ctl[0].hit_slot      = '0;
    chain_ctl[0].hit_priority  = '0;
  end
  assign chain_key[0]  = in_data.lookup_key[KEY_WIDTH-1:0];
  assign chain_mask[0] = in_data.rule_mask[KEY_WIDTH-1:0];

  // One cell per rule slot.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pmm_cell #(
      .INDEX     (i),
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .prev_ctl  (chain_ctl[i]),
      .prev_key  (chain_key[i]),
      .prev_mask (chain_mask[i]),
      .ctl_r     (chain_ctl[i+1]),
      .key_r     (chain_key[i+1]),
      .mask_r    (chain_mask[i+1])
    );
  end

  // Output register fed by the last cell.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance && tail.valid) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.status       = tail.status;
      out_data_nxt.hit          = tail.hit;
      out_data_nxt.hit_slot     = tail.hit_slot;
      out_data_nxt.hit_priority = tail.hit_priority;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/pmm_checker.sv =====
// ----------------------------------------------------------------------------
// pmm_checker
// Port-level checks of the rule table's output register and flow control.
// ----------------------------------------------------------------------------
module pmm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input pmm_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input pmm_pkg::out_item_t out_data
);

  // An input item waiting on the block holds still.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  // A result item waiting on the consumer holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // With the output free or draining, the chain always moves.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with a free output");

  // A miss carries no slot and no priority.
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> (out_data.hit_slot == '0) &&
                                   (out_data.hit_priority == '0))
    else $error("miss result with slot or priority set");

endmodule

bind priority_masked_match_table pmm_checker u_pmm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
